// File: src/boxiou_pkg.sv
// Shared types and constants for the box intersection-over-union block.
package boxiou_pkg;

    // Fixed field widths of the input and result beats.
    localparam int FIELD_BITS = 16;
    localparam int RATIO_BITS = 17;

    // One input beat: two boxes as near corner plus size.
    typedef struct packed {
        logic [FIELD_BITS-1:0] a_x;
        logic [FIELD_BITS-1:0] a_y;
        logic [FIELD_BITS-1:0] a_w;
        logic [FIELD_BITS-1:0] a_h;
        logic [FIELD_BITS-1:0] b_x;
        logic [FIELD_BITS-1:0] b_y;
        logic [FIELD_BITS-1:0] b_w;
        logic [FIELD_BITS-1:0] b_h;
    } box_pair_t;

    // One result beat.
    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio_q16;
        logic                  disjoint;
    } iou_result_t;

    // Control that travels alongside each item through the divider.
    typedef struct packed {
        logic valid;
        logic disjoint;
    } div_side_t;

endpackage

// File: src/boxiou_div.sv
// Pipelined restoring divider producing one quotient bit per stage.
module boxiou_div
    import boxiou_pkg::*;
#(
    parameter int NUM_BITS  = 32,
    parameter int DEN_BITS  = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  div_side_t            side_in,
    input  logic [NUM_BITS-1:0]  num,
    input  logic [DEN_BITS-1:0]  den,
    output div_side_t            side_out,
    output logic [FRAC_BITS:0]   quot
);

    localparam int QW = FRAC_BITS + 1;

    // Per-stage registers; the last stage keeps only the quotient and side data.
    logic [DEN_BITS-1:0] rem_reg  [0:FRAC_BITS-1];
    logic [DEN_BITS-1:0] den_reg  [0:FRAC_BITS-1];
    logic [QW-1:0]       quot_reg [0:FRAC_BITS];
    div_side_t           side_reg [0:FRAC_BITS];

    // Integer bit: one bit suffices while the numerator does not exceed the denominator.
    logic [DEN_BITS-1:0] num_ext;
    logic                int_ge;
    logic [DEN_BITS-1:0] int_rem_next;

    assign num_ext      = DEN_BITS'(num);
    assign int_ge       = (num_ext >= den);
    assign int_rem_next = int_ge ? (num_ext - den) : num_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0].valid <= 1'b0;
        end else if (en) begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= int_rem_next;
            den_reg[0]  <= den;
            quot_reg[0] <= QW'(int_ge);
        end
    end

    // Fraction bits: shift the remainder, compare, subtract.
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
        logic [DEN_BITS:0] shifted;
        logic [DEN_BITS:0] diff;
        logic              ge;

        assign shifted = {rem_reg[k-1], 1'b0};
        assign diff    = shifted - {1'b0, den_reg[k-1]};
        assign ge      = (shifted >= {1'b0, den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].valid <= 1'b0;
            end else if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[k] <= {quot_reg[k-1][QW-2:0], ge};
            end
        end

        if (k < FRAC_BITS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign side_out = side_reg[FRAC_BITS];
    assign quot     = quot_reg[FRAC_BITS];

endmodule

// File: src/box_intersection_over_union.sv
// An accepted input beat passes stages 1 to 4, the divider stages and the output register.
// Throughput: one box pair per cycle while no result beat is held; the divider resolves
// one quotient bit per stage, so its FRAC_BITS + 1 stages set the depth, not the rate.
// A held result beat stalls every stage together; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the data registers are not reset.
module box_intersection_over_union
    import boxiou_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  box_pair_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output iou_result_t m_data
);

    localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int EW = CW + 1;
    localparam int AW = 2 * CW;
    localparam int UW = AW + 1;
    localparam int QW = FRAC_BITS + 1;

    // The whole pipeline advances when the output register can take a beat.
    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage 1: far corners and the intersection corners.
    logic [CW-1:0] ax0, ay0, aw, ah, bx0, by0, bw, bh;
    logic [EW-1:0] ax1, ay1, bx1, by1;
    logic [EW-1:0] ix0_next, iy0_next, ix1_next, iy1_next;

    assign ax0 = s_data.a_x[CW-1:0];
    assign ay0 = s_data.a_y[CW-1:0];
    assign aw  = s_data.a_w[CW-1:0];
    assign ah  = s_data.a_h[CW-1:0];
    assign bx0 = s_data.b_x[CW-1:0];
    assign by0 = s_data.b_y[CW-1:0];
    assign bw  = s_data.b_w[CW-1:0];
    assign bh  = s_data.b_h[CW-1:0];

    assign ax1 = {1'b0, ax0} + {1'b0, aw};
    assign ay1 = {1'b0, ay0} + {1'b0, ah};
    assign bx1 = {1'b0, bx0} + {1'b0, bw};
    assign by1 = {1'b0, by0} + {1'b0, bh};

    assign ix0_next = (ax0 > bx0) ? {1'b0, ax0} : {1'b0, bx0};
    assign iy0_next = (ay0 > by0) ? {1'b0, ay0} : {1'b0, by0};
    assign ix1_next = (ax1 < bx1) ? ax1 : bx1;
    assign iy1_next = (ay1 < by1) ? ay1 : by1;

    logic          s1_valid_reg;
    logic [EW-1:0] s1_ix0_reg, s1_iy0_reg, s1_ix1_reg, s1_iy1_reg;
    logic [CW-1:0] s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ix0_reg <= ix0_next;
            s1_iy0_reg <= iy0_next;
            s1_ix1_reg <= ix1_next;
            s1_iy1_reg <= iy1_next;
            s1_aw_reg  <= aw;
            s1_ah_reg  <= ah;
            s1_bw_reg  <= bw;
            s1_bh_reg  <= bh;
        end
    end

    // Stage 2: overlap extents and the apart test.
    logic [EW-1:0] dx_full, dy_full;
    logic          apart_next;

    assign dx_full    = s1_ix1_reg - s1_ix0_reg;
    assign dy_full    = s1_iy1_reg - s1_iy0_reg;
    assign apart_next = (s1_ix1_reg < s1_ix0_reg) || (s1_iy1_reg < s1_iy0_reg);

    logic          s2_valid_reg;
    logic          s2_apart_reg;
    logic [CW-1:0] s2_dx_reg, s2_dy_reg;
    logic [CW-1:0] s2_aw_reg, s2_ah_reg, s2_bw_reg, s2_bh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // A nonnegative extent is at most the smaller width, so it fits in CW bits.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_apart_reg <= apart_next;
            s2_dx_reg    <= dx_full[CW-1:0];
            s2_dy_reg    <= dy_full[CW-1:0];
            s2_aw_reg    <= s1_aw_reg;
            s2_ah_reg    <= s1_ah_reg;
            s2_bw_reg    <= s1_bw_reg;
            s2_bh_reg    <= s1_bh_reg;
        end
    end

    // Stage 3: the two box areas and the overlap area.
    logic          s3_valid_reg;
    logic          s3_apart_reg;
    logic [AW-1:0] s3_area_a_reg, s3_area_b_reg, s3_overlap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_apart_reg   <= s2_apart_reg;
            s3_area_a_reg  <= AW'(s2_aw_reg) * AW'(s2_ah_reg);
            s3_area_b_reg  <= AW'(s2_bw_reg) * AW'(s2_bh_reg);
            s3_overlap_reg <= AW'(s2_dx_reg) * AW'(s2_dy_reg);
        end
    end

    // Stage 4: union area; for an intersecting pair the overlap never exceeds either area.
    logic [UW-1:0] union_next;
    assign union_next = UW'(s3_area_a_reg) + UW'(s3_area_b_reg) - UW'(s3_overlap_reg);

    div_side_t     s4_side_reg;
    logic [AW-1:0] s4_num_reg;
    logic [UW-1:0] s4_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_side_reg.valid <= 1'b0;
        end else if (adv) begin
            s4_side_reg.valid    <= s3_valid_reg;
            s4_side_reg.disjoint <= s3_apart_reg || (union_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_num_reg <= s3_overlap_reg;
            s4_den_reg <= union_next;
        end
    end

    // Divider: overlap over union in Q1.FRAC_BITS.
    div_side_t     div_side;
    logic [QW-1:0] div_quot;

    boxiou_div #(
        .NUM_BITS  (AW),
        .DEN_BITS  (UW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .side_in  (s4_side_reg),
        .num      (s4_num_reg),
        .den      (s4_den_reg),
        .side_out (div_side),
        .quot     (div_quot)
    );

    // Output register: force zero for disjoint pairs and fit the ratio field.
    logic [QW+RATIO_BITS-1:0] quot_ext;
    iou_result_t              result_next;

    assign quot_ext              = {{RATIO_BITS{1'b0}}, div_quot};
    assign result_next.ratio_q16 = div_side.disjoint ? '0 : quot_ext[RATIO_BITS-1:0];
    assign result_next.disjoint  = div_side.disjoint;

    iou_result_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_side.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A disjoint pair always reports a zero ratio.
    a_disjoint_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.disjoint |-> m_data.ratio_q16 == '0)
        else $error("disjoint result with nonzero ratio");

    // The ratio never exceeds 1.0 when the field holds the whole quotient.
    a_ratio_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (FRAC_BITS >= RATIO_BITS) ||
                    (m_data.ratio_q16 <= (RATIO_BITS'(1) << FRAC_BITS)))
        else $error("ratio above one");

    // A stall freezes the front of the pipeline.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s1_valid_reg) && $stable(s4_side_reg.valid))
        else $error("pipeline moved during a stall");

endmodule
